/* rtl/core/dqvs_pkg.sv */
// Shared types and codes for the deque with value search.
// Holds request and response transaction layouts, operation and status codes.
// No dependencies.
package dqvs_pkg;

    // Field widths of the transactions.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;

    // Default list capacity.
    localparam int DEPTH_DEFAULT = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    entry_count;
    } t_rsp;

endpackage

/* rtl/core/dqvs_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on dqvs_pkg for the payload types.
interface dqvs_req_if;
    logic             valid;
    logic             ready;
    dqvs_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dqvs_rsp_if;
    logic             valid;
    logic             ready;
    dqvs_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/dqvs_mem.sv */
// Entry storage: one write port and one read port, read data registered.
// Depends on nothing but its DEPTH and WIDTH parameters.
module dqvs_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [IW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dqvs_ctrl.sv */
// Request sequencer: ring pointers, search walk over the memory, response register.
// Depends on dqvs_pkg and the channel interfaces in dqvs_if.
module dqvs_ctrl #(
    parameter int DEPTH = 64,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    dqvs_req_if.sink                 i_req,
    dqvs_rsp_if.source               o_rsp,
    output logic                     o_mem_we,
    output logic [IW-1:0]            o_mem_waddr,
    output logic [dqvs_pkg::VALUE_W-1:0] o_mem_wdata,
    output logic                     o_mem_re,
    output logic [IW-1:0]            o_mem_raddr,
    input  logic [dqvs_pkg::VALUE_W-1:0] i_mem_rdata
);
    import dqvs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_EXT = (CW+1)'(DEPTH);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic                      r_state, n_state;
    logic [IW-1:0]             r_front, n_front;
    logic [CW-1:0]             r_occ, n_occ;
    logic [CW-1:0]             r_k, n_k;
    logic [IW-1:0]             r_addr, n_addr;
    logic signed [VALUE_W-1:0] r_key, n_key;
    logic                      r_out_valid, n_out_valid;
    t_rsp                      r_out, n_out;

    logic          out_free;
    logic          accept;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] addr_inc;
    logic [CW:0]   back_sum;
    logic [IW-1:0] back_slot;
    logic [CW-1:0] k_next;
    logic          load;
    logic [STATUS_W-1:0] rsp_status;
    logic [POS_W-1:0]    rsp_pos;

    // Handshake: one request at a time, taken only when the response slot frees.
    assign out_free      = !r_out_valid || o_rsp.ready;
    assign i_req.ready   = (r_state == S_IDLE) && out_free;
    assign accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.data    = r_out;

    // Ring arithmetic on slot indexes, wrapping at DEPTH.
    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - IW'(1);
    assign front_inc = (r_front == LAST_SLOT) ? '0 : r_front + IW'(1);
    assign addr_inc  = (r_addr == LAST_SLOT) ? '0 : r_addr + IW'(1);
    assign back_sum  = (CW+1)'(r_front) + (CW+1)'(r_occ);
    assign back_slot = (back_sum >= DEPTH_EXT) ? IW'(back_sum - DEPTH_EXT) : IW'(back_sum);
    assign k_next    = r_k + CW'(1);

    // Next-state logic for requests and the search walk.
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_occ       = r_occ;
        n_k         = r_k;
        n_addr      = r_addr;
        n_key       = r_key;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        load        = 1'b0;
        rsp_status  = ST_OK;
        rsp_pos     = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = front_dec;
        o_mem_wdata = i_req.data.value;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_addr;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    load = 1'b1;
                    case (i_req.data.operation)
                        OP_INS_FRONT: begin
                            if (r_occ == FULL_CNT) begin
                                rsp_status = ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = front_dec;
                                n_front     = front_dec;
                                n_occ       = r_occ + CW'(1);
                            end
                        end
                        OP_INS_BACK: begin
                            if (r_occ == FULL_CNT) begin
                                rsp_status = ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = back_slot;
                                n_occ       = r_occ + CW'(1);
                            end
                        end
                        OP_REM_FRONT: begin
                            if (r_occ == '0) begin
                                rsp_status = ST_EMPTY;
                            end else begin
                                n_occ   = r_occ - CW'(1);
                                n_front = (r_occ == CW'(1)) ? '0 : front_inc;
                            end
                        end
                        OP_REM_BACK: begin
                            if (r_occ == '0) begin
                                rsp_status = ST_EMPTY;
                            end else begin
                                n_occ = r_occ - CW'(1);
                                if (r_occ == CW'(1)) begin
                                    n_front = '0;
                                end
                            end
                        end
                        OP_SEARCH: begin
                            if (r_occ == '0) begin
                                rsp_status = ST_EMPTY;
                            end else begin
                                // Start the walk at the front; result comes later.
                                load        = 1'b0;
                                o_mem_re    = 1'b1;
                                o_mem_raddr = r_front;
                                n_addr      = front_inc;
                                n_k         = '0;
                                n_key       = i_req.data.value;
                                n_state     = S_SEARCH;
                            end
                        end
                        default: begin
                            rsp_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // Read data belongs to position r_k; the next read is issued alongside.
                if (i_mem_rdata == r_key) begin
                    load       = 1'b1;
                    rsp_status = ST_OK;
                    rsp_pos    = POS_W'(k_next);
                    n_state    = S_IDLE;
                end else if (k_next == r_occ) begin
                    load       = 1'b1;
                    rsp_status = ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_addr;
                    n_addr      = addr_inc;
                    n_k         = k_next;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The response register is always empty or draining when a load happens.
        if (load) begin
            n_out_valid       = 1'b1;
            n_out.status      = rsp_status;
            n_out.position    = rsp_pos;
            n_out.entry_count = POS_W'(n_occ);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_addr <= n_addr;
        r_key <= n_key;
        r_out <= n_out;
    end

endmodule

/* rtl/core/deque_with_value_search_top.sv */
// Channel     Dir  Payload                             Accepted when
// i_req       in   operation[2:0], value[31:0] signed  valid && ready
// o_rsp       out  status[1:0], position[6:0],         valid && ready
//                  entry_count[6:0]
//
// Inserts, removals and searches of an empty list load the response register at
// the edge the request is accepted. A search reads one entry per cycle from the
// entry memory through its single read port, from the front up to the first
// match or the back entry.
// Reset (i_rst_n low, synchronous) empties the list; the memory is not cleared.
// A stalled response holds the block: no request is taken until it can be replaced.
//
// Top level of the deque with value search; depends on dqvs_pkg, dqvs_if,
// dqvs_mem and dqvs_ctrl.
module deque_with_value_search_top #(
    parameter int DEPTH = dqvs_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqvs_req_if.sink    i_req,
    dqvs_rsp_if.source  o_rsp
);
    import dqvs_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    // Request sequencer.
    dqvs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Entry memory.
    dqvs_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

/* test/tb_deque_with_value_search_top.sv */
// Self-checking testbench for deque_with_value_search_top.
// Predicts every response from a shadow copy of the list and compares each field.
// Depends on dqvs_pkg, dqvs_if and the RTL of the block.
module tb_deque_with_value_search_top;
    import dqvs_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    // Operation codes that the block treats as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_SEARCH + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 250;

    typedef enum int {PH_MIXED, PH_FILL, PH_DRAIN} t_phase;

    // Shadow list that predicts one response per accepted request.
    class list_tracker;
        bit [VALUE_W-1:0] slots [DEPTH];
        int unsigned      front;
        int unsigned      fill;
        t_rsp             pending_rsps [$];
        int unsigned      errors;

        function int unsigned slot_of(int unsigned k);
            return (front + k) % DEPTH;
        endfunction

        function bit [VALUE_W-1:0] value_at(int unsigned k);
            return slots[slot_of(k)];
        endfunction

        function void note_request(t_req req);
            t_rsp rsp;
            int unsigned k;
            rsp = '0;
            rsp.status = ST_OK;
            case (req.operation)
                OP_INS_FRONT: begin
                    if (fill >= DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        front = (front + DEPTH - 1) % DEPTH;
                        slots[front] = req.value;
                        fill++;
                    end
                end
                OP_INS_BACK: begin
                    if (fill >= DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        slots[slot_of(fill)] = req.value;
                        fill++;
                    end
                end
                OP_REM_FRONT: begin
                    if (fill == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        front = (front + 1) % DEPTH;
                        fill--;
                        if (fill == 0) front = 0;
                    end
                end
                OP_REM_BACK: begin
                    if (fill == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        fill--;
                        if (fill == 0) front = 0;
                    end
                end
                OP_SEARCH: begin
                    if (fill == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        // The first match from the front wins.
                        rsp.status = ST_NOT_FOUND;
                        for (k = 0; k < fill; k++) begin
                            if (slots[slot_of(k)] == req.value) begin
                                rsp.status   = ST_OK;
                                rsp.position = POS_W'(k + 1);
                                break;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            rsp.entry_count = POS_W'(fill);
            pending_rsps.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (pending_rsps.size() == 0) begin
                $error("response with no request outstanding: status %0d position %0d count %0d",
                       got.status, got.position, got.entry_count);
                errors++;
                return;
            end
            want = pending_rsps.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dqvs_req_if req_ch ();
    dqvs_rsp_if rsp_ch ();

    list_tracker tracker = new();

    int unsigned sent;
    bit          steady;
    bit          hold_long;

    deque_with_value_search_top #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // Observe both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) tracker.note_request(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) tracker.check_response(rsp_ch.data);
        end
    end

    // Gap before a request: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r = $urandom_range(0, 99);
        if (steady || hold_long) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Operation mix depends on whether the phase grows, shrinks or churns the list.
    function automatic logic [OP_W-1:0] pick_op(t_phase ph);
        int unsigned r = $urandom_range(0, 99);
        if (r >= 97) return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        case (ph)
            PH_FILL: begin
                if (r < 45) return OP_INS_BACK;
                if (r < 80) return OP_INS_FRONT;
                if (r < 91) return OP_SEARCH;
                if (r < 94) return OP_REM_FRONT;
                return OP_REM_BACK;
            end
            PH_DRAIN: begin
                if (r < 40) return OP_REM_FRONT;
                if (r < 80) return OP_REM_BACK;
                if (r < 92) return OP_SEARCH;
                if (r < 95) return OP_INS_FRONT;
                return OP_INS_BACK;
            end
            default: return OP_W'($urandom_range(OP_INS_FRONT, OP_SEARCH));
        endcase
    endfunction

    // Searches mostly look for stored values, the back entry among them;
    // inserts often reuse a few values so that duplicates occur.
    function automatic logic [VALUE_W-1:0] pick_value(logic [OP_W-1:0] op);
        int unsigned r = $urandom_range(0, 99);
        if (op == OP_SEARCH && tracker.fill != 0) begin
            if (r < 35) return tracker.value_at($urandom_range(0, tracker.fill - 1));
            if (r < 55) return tracker.value_at(tracker.fill - 1);
        end
        if ($urandom_range(0, 1) == 0) return $urandom();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h0000_0002;
            6: return 32'h5555_5555;
            default: return 32'hAAAA_AAAA;
        endcase
    endfunction

    // Offer one request after a random gap; returns at the falling edge after acceptance.
    task automatic issue(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.data.operation <= op;
        req_ch.data.value     <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if (op < OP_SPARE_LO) sent++;
    endtask

    // Stop sending until every outstanding response has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending_rsps.size() != 0);
    endtask

    // Response side: random back-pressure, one long hold on request.
    initial begin
        int unsigned r;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_long = 1'b0;
            end else if (steady) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    rsp_ch.ready <= 1'b1;
                    repeat ($urandom_range(0, 3)) @(negedge i_clk);
                end else if (r < 90) begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(0, 2)) @(negedge i_clk);
                end else begin
                    rsp_ch.ready <= 1'b0;
                    repeat ($urandom_range(4, 30)) @(negedge i_clk);
                end
            end
        end
    end

    // Reset, directed cases, then phases of random traffic.
    initial begin
        int unsigned round;
        t_phase      ph;
        int unsigned n_items;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.data      = '0;
        steady           = 1'b0;
        hold_long        = 1'b0;
        sent             = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Requests on an empty list, then the unused operation codes.
        issue(OP_REM_FRONT, 32'h0000_0000);
        issue(OP_REM_BACK, 32'hFFFF_FFFF);
        issue(OP_SEARCH, 32'h0000_0000);
        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) issue(OP_W'(c), $urandom());

        // Build a short list with extreme values, a duplicate, and a back insert on empty.
        issue(OP_INS_BACK, 32'h8000_0000);
        issue(OP_INS_FRONT, 32'h7FFF_FFFF);
        issue(OP_INS_BACK, 32'hFFFF_FFFF);
        issue(OP_INS_FRONT, 32'h0000_0000);
        issue(OP_INS_BACK, 32'h0000_0000);
        issue(OP_INS_BACK, 32'h1234_5678);

        // Hits on the last, first and a middle entry, and a miss.
        issue(OP_SEARCH, 32'h1234_5678);
        issue(OP_SEARCH, 32'h0000_0000);
        issue(OP_SEARCH, 32'h8000_0000);
        issue(OP_SEARCH, 32'h0000_0001);
        issue(OP_SPARE_HI, 32'h0000_0000);

        // Remove from both ends, then empty the list and underflow once more.
        issue(OP_REM_FRONT, $urandom());
        issue(OP_REM_BACK, $urandom());
        issue(OP_SEARCH, 32'h0000_0000);
        repeat (4) issue(OP_REM_FRONT, $urandom());
        issue(OP_REM_BACK, $urandom());

        // Front insert on an empty list, found again.
        issue(OP_INS_FRONT, 32'h5A5A_5A5A);
        issue(OP_SEARCH, 32'h5A5A_5A5A);
        wait_drained();

        round = 0;
        n_items = sent + RANDOM_ITEMS;
        while (sent < n_items) begin
            ph = t_phase'(round % 3);
            steady = (round == 4);
            if (round == 1) hold_long = 1'b1;
            repeat ((ph == PH_MIXED) ? 40 : 110) begin
                logic [OP_W-1:0] op;
                if (sent < n_items) begin
                    op = pick_op(ph);
                    issue(op, pick_value(op));
                end
            end
            steady = 1'b0;
            if ($urandom_range(0, 3) == 0) wait_drained();
            round++;
        end
        req_ch.valid <= 1'b0;

        // Let the last responses arrive, then allow for a full search more.
        while (tracker.pending_rsps.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("PASS deque_with_value_search_top");
        end else begin
            $display("FAIL deque_with_value_search_top");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("FAIL deque_with_value_search_top");
        $finish;
    end

endmodule
